FILE: design/bsc_pkg.sv
// shared constants, payload types and helpers for the safety check block
`default_nettype none

package bsc_pkg;

  localparam int MAX_PROCESSES = 16;
  localparam int MAX_RESOURCES = 8;
  localparam int AMOUNT_WIDTH  = 16;

  localparam int PROC_W      = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  localparam int PROC_CNT_W  = $clog2(MAX_PROCESSES + 1);
  localparam int RES_W       = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
  localparam int RES_CNT_W   = $clog2(MAX_RESOURCES + 1);
  localparam int TABLE_DEPTH = MAX_PROCESSES * MAX_RESOURCES;
  localparam int TABLE_AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int WORK_W      = AMOUNT_WIDTH + $clog2(MAX_PROCESSES + 1);

  // fixed field widths of the ports
  localparam int NP_W        = 5;
  localparam int NR_W        = 4;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 5;

  localparam logic [1:0] ACT_MATRIX = 2'd0;
  localparam logic [1:0] ACT_AVAIL  = 2'd1;
  localparam logic [1:0] ACT_CHECK  = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_PROCESSES = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_RESOURCES = 1'b1;

  typedef struct packed {
    logic [1:0]  action;
    logic [3:0]  process_index;
    logic [2:0]  resource_index;
    logic [15:0] alloc_amount;
    logic [15:0] need_amount;
    logic [15:0] avail_amount;
  } bsc_in_t;

  typedef struct packed {
    logic [3:0] seq_process;
    logic       is_verdict;
    logic       is_safe;
    logic       last;
  } bsc_out_t;

  // table write request from the control side
  typedef struct packed {
    logic                    en;
    logic [TABLE_AW-1:0]     addr;
    logic [AMOUNT_WIDTH-1:0] alloc;
    logic [AMOUNT_WIDTH-1:0] need;
  } bsc_wr_t;

  function automatic logic [TABLE_AW-1:0] table_addr(input logic [PROC_W-1:0] p,
                                                     input logic [RES_W-1:0] r);
    return TABLE_AW'(p * MAX_RESOURCES + r);
  endfunction

endpackage

`default_nettype wire

FILE: design/bsc_tables.sv
// allocation and need tables, one write port and one registered read port
`default_nettype none

module bsc_tables (
  input  wire logic                             clk,
  input  wire bsc_pkg::bsc_wr_t                 wr,
  input  wire logic [bsc_pkg::TABLE_AW-1:0]     raddr,
  output logic      [bsc_pkg::AMOUNT_WIDTH-1:0] alloc_rd,
  output logic      [bsc_pkg::AMOUNT_WIDTH-1:0] need_rd
);
  import bsc_pkg::*;

  logic [AMOUNT_WIDTH-1:0] alloc_mem [TABLE_DEPTH];
  logic [AMOUNT_WIDTH-1:0] need_mem  [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      alloc_mem[wr.addr] <= wr.alloc;
      need_mem[wr.addr]  <= wr.need;
    end
    alloc_rd <= alloc_mem[raddr];
    need_rd  <= need_mem[raddr];
  end

endmodule

`default_nettype wire

FILE: design/banker_safety_check.sv
// load words: one per cycle, back to back, no result; a check word stalls the input until done
// check: a setup step, then a visit to each process slot; an unfinished one reads and compares
//   each resource; if all fit it reads and adds each allocation, emits; a step ends each sweep
// sweeps repeat until one finds nothing, then the verdict is issued; a held result word
//   stalls the sequencer, which shares one table read port, one compare and one adder
// reset: 16 processes, 8 resources, work and finished mask clear, tables and available undefined
`default_nettype none

module banker_safety_check (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire bsc_pkg::bsc_in_t                 in_data,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output bsc_pkg::bsc_out_t                     out_data,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [bsc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [bsc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import bsc_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_INIT = 4'd1;
  localparam logic [3:0] S_PROC = 4'd2;
  localparam logic [3:0] S_RD   = 4'd3;
  localparam logic [3:0] S_CMP  = 4'd4;
  localparam logic [3:0] S_ARD  = 4'd5;
  localparam logic [3:0] S_ADD  = 4'd6;
  localparam logic [3:0] S_EMIT = 4'd7;
  localparam logic [3:0] S_VERD = 4'd8;

  logic [3:0]               state;
  logic [NP_W-1:0]          processes_in_use;
  logic [NR_W-1:0]          resources_in_use;
  logic [PROC_CNT_W-1:0]    i;
  logic [RES_CNT_W-1:0]     j;
  logic                     found;
  logic [MAX_PROCESSES-1:0] finished;

  logic [AMOUNT_WIDTH-1:0]  avail [MAX_RESOURCES];
  logic [WORK_W-1:0]        work  [MAX_RESOURCES];

  logic                     in_accept;
  logic                     out_free;
  logic                     out_load;
  logic [PROC_CNT_W-1:0]    np_eff;
  logic [RES_CNT_W-1:0]     nr_eff;
  logic [PROC_CNT_W-1:0]    i_inc;
  logic [RES_CNT_W-1:0]     j_inc;
  logic [PROC_W-1:0]        i_idx;
  logic [RES_W-1:0]         j_idx;
  logic                     all_done;
  logic                     need_over;

  bsc_wr_t                  tbl_wr;
  logic [AMOUNT_WIDTH-1:0]  alloc_rd;
  logic [AMOUNT_WIDTH-1:0]  need_rd;

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;
  assign out_load  = out_free && (state == S_EMIT || state == S_VERD);

  // counts above the maximum act as the maximum
  assign np_eff = (processes_in_use > MAX_PROCESSES) ? PROC_CNT_W'(MAX_PROCESSES)
                                                     : PROC_CNT_W'(processes_in_use);
  assign nr_eff = (resources_in_use > MAX_RESOURCES) ? RES_CNT_W'(MAX_RESOURCES)
                                                     : RES_CNT_W'(resources_in_use);

  assign i_inc = i + 1'b1;
  assign j_inc = j + 1'b1;
  assign i_idx = i[PROC_W-1:0];
  assign j_idx = j[RES_W-1:0];

  assign need_over = WORK_W'(need_rd) > work[j_idx];

  always_comb begin
    all_done = 1'b1;
    for (int k = 0; k < MAX_PROCESSES; k++) begin
      if (k < np_eff && !finished[k]) begin
        all_done = 1'b0;
      end
    end
  end

  always_comb begin
    tbl_wr.en    = in_accept && (in_data.action == ACT_MATRIX) &&
                   (in_data.process_index < MAX_PROCESSES) &&
                   (in_data.resource_index < MAX_RESOURCES);
    tbl_wr.addr  = table_addr(PROC_W'(in_data.process_index),
                              RES_W'(in_data.resource_index));
    tbl_wr.alloc = AMOUNT_WIDTH'(in_data.alloc_amount);
    tbl_wr.need  = AMOUNT_WIDTH'(in_data.need_amount);
  end

  bsc_tables u_tables (
    .clk      (clk),
    .wr       (tbl_wr),
    .raddr    (table_addr(i_idx, j_idx)),
    .alloc_rd (alloc_rd),
    .need_rd  (need_rd)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      processes_in_use <= NP_W'(16);
      resources_in_use <= NR_W'(8);
      i                <= '0;
      j                <= '0;
      found            <= 1'b0;
      finished         <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_PROCESSES: processes_in_use <= cfg_data[NP_W-1:0];
          REG_RESOURCES: resources_in_use <= cfg_data[NR_W-1:0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_accept && in_data.action == ACT_CHECK) begin
            state <= S_INIT;
          end
        end
        S_INIT: begin
          finished <= '0;
          i        <= '0;
          found    <= 1'b0;
          state    <= S_PROC;
        end
        S_PROC: begin
          if (i >= np_eff) begin
            // end of a sweep: go again only if it found something
            if (found) begin
              found <= 1'b0;
              i     <= '0;
            end else begin
              state <= S_VERD;
            end
          end else if (finished[i_idx]) begin
            i <= i_inc;
          end else if (nr_eff == '0) begin
            state <= S_EMIT;
          end else begin
            j     <= '0;
            state <= S_RD;
          end
        end
        S_RD: state <= S_CMP;
        S_CMP: begin
          if (need_over) begin
            i     <= i_inc;
            state <= S_PROC;
          end else if (j_inc == nr_eff) begin
            j     <= '0;
            state <= S_ARD;
          end else begin
            j     <= j_inc;
            state <= S_RD;
          end
        end
        S_ARD: state <= S_ADD;
        S_ADD: begin
          if (j_inc == nr_eff) begin
            state <= S_EMIT;
          end else begin
            j     <= j_inc;
            state <= S_ARD;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            finished[i_idx] <= 1'b1;
            found           <= 1'b1;
            i               <= i_inc;
            state           <= S_PROC;
          end
        end
        S_VERD: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // available vector, written by load words
  always_ff @(posedge clk) begin
    if (in_accept && in_data.action == ACT_AVAIL && in_data.resource_index < MAX_RESOURCES) begin
      avail[RES_W'(in_data.resource_index)] <= AMOUNT_WIDTH'(in_data.avail_amount);
    end
  end

  // work vector
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MAX_RESOURCES; k++) begin
        work[k] <= '0;
      end
    end else if (state == S_INIT) begin
      for (int k = 0; k < MAX_RESOURCES; k++) begin
        work[k] <= WORK_W'(avail[k]);
      end
    end else if (state == S_ADD) begin
      work[j_idx] <= work[j_idx] + WORK_W'(alloc_rd);
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (state == S_EMIT && out_free) begin
      out_data.seq_process <= 4'(i_idx);
      out_data.is_verdict  <= 1'b0;
      out_data.is_safe     <= 1'b0;
      out_data.last        <= 1'b0;
    end else if (state == S_VERD && out_free) begin
      out_data.seq_process <= '0;
      out_data.is_verdict  <= 1'b1;
      out_data.is_safe     <= all_done;
      out_data.last        <= 1'b1;
    end
  end

  a_check_starts: assert property (@(posedge clk) disable iff (rst)
    in_accept && in_data.action == ACT_CHECK |=> state == S_INIT)
    else $error("check word did not start a run");

  a_seq_finished: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.is_verdict |-> finished[PROC_W'(out_data.seq_process)])
    else $error("sequence word names an unfinished process");

  a_verdict_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.is_verdict == out_data.last)
    else $error("verdict and last disagree");

  a_verdict_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_VERD && out_free |=> state == S_IDLE && out_valid && out_data.is_verdict)
    else $error("verdict not issued on leaving the run");

  a_emit_unfinished: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT |-> !finished[i_idx] && i < np_eff)
    else $error("emitting a process that is finished or out of range");

endmodule

`default_nettype wire

FILE: tb/sv/banker_safety_check_tb.sv
// self-checking bench for banker_safety_check: directed and random load and check words
module banker_safety_check_tb;
  import bsc_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 350;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_CYCLES  = 400;
  localparam int IDLE_PCT     = 11;
  localparam int REPORT_LIMIT = 10;

  class safe_sequence_tracker;
    logic [AMOUNT_WIDTH-1:0] alloc_amt [MAX_PROCESSES][MAX_RESOURCES];
    logic [AMOUNT_WIDTH-1:0] need_amt [MAX_PROCESSES][MAX_RESOURCES];
    logic [AMOUNT_WIDTH-1:0] avail_amt [MAX_RESOURCES];
    logic [NP_W-1:0] proc_count;
    logic [NR_W-1:0] res_count;
    bsc_out_t expected_seq[$];
    int errors;

    function new();
      proc_count = 5'd16;
      res_count = 4'd8;
      errors = 0;
    endfunction

    function void set_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
      if (idx == REG_PROCESSES) proc_count = val;
      else res_count = val[NR_W-1:0];
    endfunction

    // sweep the processes until one pass finds nothing, queueing each finisher and a verdict
    function void predict_safe_sequence();
      logic [WORK_W-1:0] work [MAX_RESOURCES];
      logic [MAX_PROCESSES-1:0] done;
      int np, nr;
      bit found, fits, all_done;
      bsc_out_t r;
      np = (proc_count > MAX_PROCESSES) ? MAX_PROCESSES : proc_count;
      nr = (res_count > MAX_RESOURCES) ? MAX_RESOURCES : res_count;
      done = '0;
      for (int j = 0; j < MAX_RESOURCES; j++) work[j] = WORK_W'(avail_amt[j]);
      found = 1'b1;
      while (found) begin
        found = 1'b0;
        for (int i = 0; i < np; i++) begin
          if (!done[i]) begin
            fits = 1'b1;
            for (int j = 0; j < nr; j++)
              if (need_amt[i][j] > work[j]) fits = 1'b0;
            if (fits) begin
              for (int j = 0; j < nr; j++) work[j] = work[j] + WORK_W'(alloc_amt[i][j]);
              done[i] = 1'b1;
              found = 1'b1;
              r = '0;
              r.seq_process = i[3:0];
              expected_seq = {expected_seq, r};
            end
          end
        end
      end
      all_done = 1'b1;
      for (int i = 0; i < np; i++)
        if (!done[i]) all_done = 1'b0;
      r = '0;
      r.is_verdict = 1'b1;
      r.is_safe = all_done;
      r.last = 1'b1;
      expected_seq = {expected_seq, r};
    endfunction

    function void note_word(input bsc_in_t w);
      case (w.action)
        ACT_MATRIX: begin
          alloc_amt[w.process_index][w.resource_index] = w.alloc_amount;
          need_amt[w.process_index][w.resource_index] = w.need_amount;
        end
        ACT_AVAIL: avail_amt[w.resource_index] = w.avail_amount;
        ACT_CHECK: predict_safe_sequence();
        default: ;
      endcase
    endfunction

    function void check_word(input bsc_out_t got);
      bsc_out_t want;
      if (expected_seq.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("unexpected result word: proc %0d verdict %0b safe %0b last %0b",
                   got.seq_process, got.is_verdict, got.is_safe, got.last);
      end else begin
        want = expected_seq.pop_front();
        if (got.seq_process !== want.seq_process || got.is_verdict !== want.is_verdict ||
            got.is_safe !== want.is_safe || got.last !== want.last) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display("mismatch: exp p%0d v%0b s%0b l%0b got p%0d v%0b s%0b l%0b",
                     want.seq_process, want.is_verdict, want.is_safe, want.last,
                     got.seq_process, got.is_verdict, got.is_safe, got.last);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  bsc_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  bsc_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  safe_sequence_tracker board;
  bit entry_loaded [MAX_PROCESSES][MAX_RESOURCES];
  bit avail_loaded [MAX_RESOURCES];
  int np_active = MAX_PROCESSES;
  int nr_active = MAX_RESOURCES;
  int words_sent = 0;
  int results_seen = 0;
  bit sender_quiet = 1'b0;
  bit hold_request = 1'b0;
  bit hold_done = 1'b0;

  banker_safety_check uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic [15:0] pick_amount();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 45) return 16'($urandom_range(0, 7));
    else if (sel < 65) return 16'($urandom_range(0, 40));
    else if (sel < 85) return 16'($urandom);
    else if (sel < 93) return 16'hFFFF;
    else return 16'h0000;
  endfunction

  function automatic int pick_np();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 5) return 0;
    if (sel < 15) return MAX_PROCESSES;
    if (sel < 22) return $urandom_range(17, 31);
    return $urandom_range(1, 8);
  endfunction

  function automatic int pick_nr();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 5) return 0;
    if (sel < 20) return MAX_RESOURCES;
    if (sel < 27) return $urandom_range(9, 15);
    if (sel < 32) return $urandom_range(16, 31);
    return $urandom_range(1, 4);
  endfunction

  // fields the action does not use still carry random bits
  function automatic bsc_in_t random_word(input logic [1:0] act);
    bsc_in_t w;
    w.action = act;
    w.process_index = 4'($urandom_range(0, 15));
    w.resource_index = 3'($urandom_range(0, 7));
    w.alloc_amount = 16'($urandom);
    w.need_amount = 16'($urandom);
    w.avail_amount = 16'($urandom);
    return w;
  endfunction

  // valid stays up from one word to the next unless a gap is drawn
  task automatic send_word(input bsc_in_t w);
    if (!sender_quiet && !(words_sent >= 120 && words_sent < 200) &&
        $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
    board.note_word(w);
  endtask

  task automatic load_matrix(input int p, input int r, input logic [15:0] alloc,
                             input logic [15:0] need);
    bsc_in_t w;
    w = random_word(ACT_MATRIX);
    w.process_index = p[3:0];
    w.resource_index = r[2:0];
    w.alloc_amount = alloc;
    w.need_amount = need;
    entry_loaded[p][r] = 1'b1;
    send_word(w);
  endtask

  task automatic load_avail(input int r, input logic [15:0] amount);
    bsc_in_t w;
    w = random_word(ACT_AVAIL);
    w.resource_index = r[2:0];
    w.avail_amount = amount;
    avail_loaded[r] = 1'b1;
    send_word(w);
  endtask

  // every entry the check will read gets loaded first
  task automatic run_check();
    for (int r = 0; r < MAX_RESOURCES; r++)
      if (!avail_loaded[r]) load_avail(r, pick_amount());
    for (int p = 0; p < np_active; p++)
      for (int r = 0; r < nr_active; r++)
        if (!entry_loaded[p][r]) load_matrix(p, r, pick_amount(), pick_amount());
    send_word(random_word(ACT_CHECK));
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (board.expected_seq.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(input int np, input int nr);
    cfg_valid <= 1'b1;
    cfg_index <= REG_PROCESSES;
    cfg_data <= np[4:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.set_reg(REG_PROCESSES, np[4:0]);
    cfg_index <= REG_RESOURCES;
    cfg_data <= nr[4:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.set_reg(REG_RESOURCES, nr[4:0]);
    cfg_valid <= 1'b0;
    np_active = (np[4:0] > MAX_PROCESSES) ? MAX_PROCESSES : np[4:0];
    nr_active = (nr[3:0] > MAX_RESOURCES) ? MAX_RESOURCES : nr[3:0];
  endtask

  // result side: random stalls, one long hold-off, and a stretch with none
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        results_seen++;
        board.check_word(out_data);
      end
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (results_seen >= 60 && results_seen < 160) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  initial begin
    #40000000;
    $display("** banker_safety_check: FAILED **");
    $finish;
  end

  initial begin
    int phase;
    int sel;
    int directed_words;
    board = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    write_config(1, 1);
    load_avail(0, 16'h0000);
    load_matrix(0, 0, 16'hFFFF, 16'h0000);
    run_check();
    // need one above work, then exactly equal to it
    load_matrix(0, 0, 16'h0000, 16'hFFFF);
    load_avail(0, 16'hFFFE);
    run_check();
    send_word(random_word(ACT_UNUSED));
    load_avail(0, 16'hFFFF);
    run_check();
    settle();
    write_config(0, 0);
    run_check();
    settle();
    write_config(MAX_PROCESSES, 0);
    run_check();
    // work has to carry past the amount width for the later processes to fit
    settle();
    write_config(3, 1);
    load_matrix(0, 0, 16'hFFFF, 16'h0000);
    load_matrix(1, 0, 16'hFFFF, 16'hFFFF);
    load_matrix(2, 0, 16'h1234, 16'hFFFF);
    load_avail(0, 16'h0001);
    run_check();
    // order found over several sweeps differs from index order
    settle();
    write_config(3, 2);
    load_matrix(0, 0, 5, 9);
    load_matrix(0, 1, 0, 0);
    load_matrix(1, 0, 4, 3);
    load_matrix(1, 1, 1, 2);
    load_matrix(2, 0, 2, 7);
    load_matrix(2, 1, 0, 1);
    load_avail(0, 3);
    load_avail(1, 2);
    run_check();
    directed_words = words_sent;

    phase = 0;
    while (words_sent < directed_words + RANDOM_ITEMS) begin
      if (phase % 4 == 0 || $urandom_range(0, 3) == 0) begin
        settle();
        write_config(pick_np(), pick_nr());
      end
      if (phase == 9) begin
        // results held back while checks keep coming, so the block backs up
        sender_quiet = 1'b1;
        hold_request <= 1'b1;
        run_check();
        repeat (4) load_matrix($urandom_range(0, 15), $urandom_range(0, 7),
                               pick_amount(), pick_amount());
        run_check();
        run_check();
        sender_quiet = 1'b0;
      end else begin
        repeat ($urandom_range(1, 8)) begin
          sel = $urandom_range(0, 99);
          if (sel < 80)
            load_matrix((np_active > 0 && $urandom_range(0, 3) != 0) ?
                          $urandom_range(0, np_active - 1) : $urandom_range(0, 15),
                        (nr_active > 0 && $urandom_range(0, 3) != 0) ?
                          $urandom_range(0, nr_active - 1) : $urandom_range(0, 7),
                        pick_amount(), pick_amount());
          else if (sel < 94)
            load_avail($urandom_range(0, 7), pick_amount());
          else
            send_word(random_word(ACT_UNUSED));
        end
        run_check();
      end
      phase++;
    end

    in_valid <= 1'b0;
    while (board.expected_seq.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (board.errors == 0) begin
      $display("** banker_safety_check: PASSED **");
    end else begin
      $display("** banker_safety_check: FAILED **");
    end
    $finish;
  end

endmodule
